FILE: hdl/csvrs_pkg.sv
// Shared constants and types of the CSV record splitter.
`timescale 1ns / 1ps

package csvrs_pkg;

   localparam int FIELD_BYTES = 64;
   localparam int MAX_COLUMNS = 255;
   localparam int ADDR_W      = $clog2(FIELD_BYTES);
   localparam int LEN_W       = $clog2(FIELD_BYTES + 2);
   localparam int COL_W       = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] QUOTE_CH = 8'd34;
   localparam logic [7:0] COMMA_CH = 8'd44;
   localparam logic [7:0] LINE_CH  = 8'd10;

   localparam logic KIND_TEXT = 1'b0;
   localparam logic KIND_EOS  = 1'b1;

   // One field to drain, or the marker of a stream that ended inside quotes.
   typedef struct packed {
      logic             start;
      logic [LEN_W-1:0] stop;
      logic             rec_end;
      logic [COL_W-1:0] cols;
      logic             ovf;
      logic             unterm;
   } cmd_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } wr_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

endpackage

FILE: hdl/csvrs_front.sv
// Front end: quote tracking, field buffering and drain commands.
`timescale 1ns / 1ps

module csvrs_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic [7:0]         req_data_byte,
   input  logic               go,
   output logic               cmd_push,
   output csvrs_pkg::cmd_type cmd_data,
   output csvrs_pkg::wr_type  buf_wr
);
   import csvrs_pkg::*;

   logic             in_quotes_ff, in_quotes_in;
   logic             quote_pending_ff, quote_pending_in;
   logic             at_record_start_ff, at_record_start_in;
   logic [LEN_W-1:0] field_length_ff, field_length_in;
   logic             overflow_seen_ff, overflow_seen_in;
   logic [COL_W-1:0] columns_ff, columns_in;
   logic             first_quote_ff, first_quote_in;
   logic             last_quote_ff, last_quote_in;

   logic             accept;
   logic             is_quote;
   logic             has_room;
   logic             toggled;
   logic             do_store, do_emit, emit_rec, emit_unterm;
   logic             clr_field, clr_record;
   logic             strip;
   logic [COL_W-1:0] cnt_next;

   assign req_ready = go;
   assign accept    = req_valid && req_ready;
   assign is_quote  = (req_data_byte == QUOTE_CH);
   assign has_room  = (field_length_ff < LEN_W'(FIELD_BYTES));
   assign cnt_next  = (columns_ff == COL_W'(MAX_COLUMNS)) ? COL_W'(MAX_COLUMNS)
                                                           : columns_ff + 1'b1;

   always_comb begin
      in_quotes_in       = in_quotes_ff;
      quote_pending_in   = quote_pending_ff;
      at_record_start_in = at_record_start_ff;
      field_length_in    = field_length_ff;
      overflow_seen_in   = overflow_seen_ff;
      columns_in         = columns_ff;
      first_quote_in     = first_quote_ff;
      last_quote_in      = last_quote_ff;
      toggled            = in_quotes_ff;
      do_store           = 1'b0;
      do_emit            = 1'b0;
      emit_rec           = 1'b0;
      emit_unterm        = 1'b0;
      clr_field          = 1'b0;
      clr_record         = 1'b0;

      if (accept) begin
         if (req_kind == KIND_EOS) begin
            toggled = in_quotes_ff ^ quote_pending_ff;
            if (toggled) begin
               do_emit     = 1'b1;
               emit_rec    = 1'b1;
               emit_unterm = 1'b1;
            end else if (!at_record_start_ff) begin
               do_emit  = 1'b1;
               emit_rec = 1'b1;
            end
            clr_record = 1'b1;
         end else begin
            at_record_start_in = 1'b0;
            quote_pending_in   = 1'b0;
            if (quote_pending_ff && is_quote) begin
               // doubled quote: literal pair, mode unchanged
               do_store = 1'b1;
            end else begin
               if (quote_pending_ff) toggled = ~in_quotes_ff;
               in_quotes_in = toggled;
               if (is_quote) begin
                  do_store         = 1'b1;
                  quote_pending_in = 1'b1;
               end else if (!toggled && req_data_byte == COMMA_CH) begin
                  do_emit   = 1'b1;
                  clr_field = 1'b1;
               end else if (!toggled && req_data_byte == LINE_CH) begin
                  do_emit    = 1'b1;
                  emit_rec   = 1'b1;
                  clr_record = 1'b1;
               end else begin
                  do_store = 1'b1;
               end
            end
         end
      end

      if (do_store) begin
         if (has_room) begin
            field_length_in = field_length_ff + 1'b1;
            if (field_length_ff == '0) first_quote_in = is_quote;
            last_quote_in = is_quote;
         end else begin
            overflow_seen_in = 1'b1;
         end
      end

      if (do_emit && !emit_unterm) columns_in = cnt_next;

      if (clr_field || clr_record) begin
         field_length_in  = '0;
         overflow_seen_in = 1'b0;
      end
      if (clr_record) begin
         in_quotes_in       = 1'b0;
         quote_pending_in   = 1'b0;
         at_record_start_in = 1'b1;
         columns_in         = '0;
      end
   end

   assign strip = (field_length_ff != '0) && first_quote_ff && last_quote_ff;

   always_comb begin
      cmd_push         = do_emit;
      cmd_data.start   = strip;
      cmd_data.stop    = strip ? field_length_ff - 1'b1 : field_length_ff;
      cmd_data.rec_end = emit_rec;
      cmd_data.unterm  = emit_unterm;
      cmd_data.ovf     = emit_unterm ? 1'b0 : overflow_seen_ff;
      if (emit_unterm) cmd_data.cols = columns_ff;
      else if (emit_rec) cmd_data.cols = cnt_next;
      else cmd_data.cols = '0;
   end

   assign buf_wr.we   = do_store && has_room;
   assign buf_wr.addr = field_length_ff[ADDR_W-1:0];
   assign buf_wr.data = req_data_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_quotes_ff       <= 1'b0;
         quote_pending_ff   <= 1'b0;
         at_record_start_ff <= 1'b1;
         field_length_ff    <= '0;
         overflow_seen_ff   <= 1'b0;
         columns_ff         <= '0;
      end else begin
         in_quotes_ff       <= in_quotes_in;
         quote_pending_ff   <= quote_pending_in;
         at_record_start_ff <= at_record_start_in;
         field_length_ff    <= field_length_in;
         overflow_seen_ff   <= overflow_seen_in;
         columns_ff         <= columns_in;
      end
   end

   always_ff @(posedge clock) begin
      first_quote_ff <= first_quote_in;
      last_quote_ff  <= last_quote_in;
   end

endmodule

FILE: hdl/csvrs_cmd_queue.sv
// Short FIFO of drain commands between front and back.
`timescale 1ns / 1ps

module csvrs_cmd_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  csvrs_pkg::cmd_type          push_data,
   input  logic                        pop,
   output csvrs_pkg::cmd_type          head,
   output csvrs_pkg::queue_status_type status
);
   import csvrs_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign do_push          = push && !status.full;
   assign do_pop           = pop && status.not_empty;
   assign head             = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slots_ff[wr_ptr_ff] <= push_data;
   end

endmodule

FILE: hdl/csvrs_back.sv
// Back end: field buffer and the unescaping drain sequencer with its output register.
`timescale 1ns / 1ps

module csvrs_back (
   input  logic                        clock,
   input  logic                        reset,
   input  csvrs_pkg::wr_type           buf_wr,
   input  csvrs_pkg::cmd_type          cmd_head,
   input  csvrs_pkg::queue_status_type q_status,
   output logic                        cmd_pop,
   output logic                        idle,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_byte_valid,
   output logic                        rsp_field_end,
   output logic                        rsp_record_end,
   output logic [7:0]                  rsp_column_count,
   output logic                        rsp_unterminated,
   output logic                        rsp_field_overflow
);
   import csvrs_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;
   localparam logic [1:0] ST_MARK  = 2'd3;

   logic [7:0]       field_mem [FIELD_BYTES];
   logic [7:0]       rd0_ff, rd1_ff;

   logic [1:0]       state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [LEN_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0] pos_plus1, pos_next;
   logic             pair, last;

   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic             out_bvalid_ff, out_bvalid_in;
   logic             out_fend_ff, out_fend_in;
   logic             out_rend_ff, out_rend_in;
   logic [COL_W-1:0] out_cols_ff, out_cols_in;
   logic             out_unterm_ff, out_unterm_in;
   logic             out_ovf_ff, out_ovf_in;
   logic             slot_free, load;

   assign idle      = (state_ff == ST_IDLE);
   assign cmd_pop   = idle && q_status.not_empty;
   assign slot_free = !out_valid_ff || rsp_ready;
   assign pos_plus1 = pos_ff + 1'b1;
   assign pair      = (rd0_ff == QUOTE_CH) && (pos_plus1 < cmd_ff.stop) && (rd1_ff == QUOTE_CH);
   assign pos_next  = pair ? pos_ff + LEN_W'(2) : pos_plus1;
   assign last      = (pos_next >= cmd_ff.stop);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      pos_in        = pos_ff;
      load          = 1'b0;
      out_byte_in   = out_byte_ff;
      out_bvalid_in = out_bvalid_ff;
      out_fend_in   = out_fend_ff;
      out_rend_in   = out_rend_ff;
      out_cols_in   = out_cols_ff;
      out_unterm_in = out_unterm_ff;
      out_ovf_in    = out_ovf_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_status.not_empty) begin
               cmd_in = cmd_head;
               pos_in = {{(LEN_W-1){1'b0}}, cmd_head.start};
               if (cmd_head.unterm || ({{(LEN_W-1){1'b0}}, cmd_head.start} >= cmd_head.stop))
                  state_in = ST_MARK;
               else
                  state_in = ST_FETCH;
            end
         end
         ST_FETCH: state_in = ST_EMIT;
         ST_EMIT: begin
            if (slot_free) begin
               load          = 1'b1;
               out_byte_in   = rd0_ff;
               out_bvalid_in = 1'b1;
               out_fend_in   = last;
               out_rend_in   = last && cmd_ff.rec_end;
               out_cols_in   = last ? cmd_ff.cols : '0;
               out_unterm_in = 1'b0;
               out_ovf_in    = last && cmd_ff.ovf;
               pos_in        = pos_next;
               state_in      = last ? ST_IDLE : ST_FETCH;
            end
         end
         ST_MARK: begin
            if (slot_free) begin
               load          = 1'b1;
               out_byte_in   = '0;
               out_bvalid_in = 1'b0;
               out_fend_in   = 1'b1;
               out_rend_in   = cmd_ff.rec_end;
               out_cols_in   = cmd_ff.cols;
               out_unterm_in = cmd_ff.unterm;
               out_ovf_in    = cmd_ff.ovf;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (load) out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
      else out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (buf_wr.we) field_mem[buf_wr.addr] <= buf_wr.data;
      if (state_ff == ST_FETCH) begin
         rd0_ff <= field_mem[pos_ff[ADDR_W-1:0]];
         rd1_ff <= field_mem[pos_plus1[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      pos_ff        <= pos_in;
      out_byte_ff   <= out_byte_in;
      out_bvalid_ff <= out_bvalid_in;
      out_fend_ff   <= out_fend_in;
      out_rend_ff   <= out_rend_in;
      out_cols_ff   <= out_cols_in;
      out_unterm_ff <= out_unterm_in;
      out_ovf_ff    <= out_ovf_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_out_byte       = out_byte_ff;
   assign rsp_byte_valid     = out_bvalid_ff;
   assign rsp_field_end      = out_fend_ff;
   assign rsp_record_end     = out_rend_ff;
   assign rsp_column_count   = out_cols_ff;
   assign rsp_unterminated   = out_unterm_ff;
   assign rsp_field_overflow = out_ovf_ff;

`ifndef SYNTH
   a_mid_is_byte: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_fend_ff) |-> out_bvalid_ff)
      else $error("result inside a field carries no byte");
   a_unterm_shape: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_unterm_ff) |-> (out_fend_ff && out_rend_ff && !out_bvalid_ff))
      else $error("unterminated marker has wrong flags");
   a_cols_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_rend_ff) |-> (out_cols_ff == '0))
      else $error("column count outside record end");
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !q_status.not_empty) |=> (state_ff == ST_IDLE))
      else $error("drain started without a command");
`endif

endmodule

FILE: hdl/csv_record_splitter.sv
// Top level of the CSV record splitter.
//
// Input channel (req_*): one item per transfer, either a text byte (req_kind 0,
// req_data_byte) or end of stream (req_kind 1). Result channel (rsp_*): one
// unescaped field byte per transfer; the last result of a field has
// rsp_field_end set, and rsp_record_end with rsp_column_count on the record's
// last field. Empty fields and an unterminated stream give one marker result
// with rsp_byte_valid low.
// A text byte that does not end a field is taken while the drain sequencer is
// idle and the command queue is empty. A delimiter or end of stream queues a
// drain of the buffered field; new input waits until the drain sequencer is
// idle again. The sequencer takes the command from the queue, then for each
// emitted byte reads the buffer and loads the output register; an empty field
// or a marker goes straight from the command to the output register load.
// Results sit in an output register: while rsp_ready is low the drain holds, and
// since input waits for an idle drain, the stall reaches the input at the next
// delimiter or end of stream. Synchronous reset returns the parser to record
// start and empties the queue and the output register; the field buffer needs
// no clearing.
`timescale 1ns / 1ps

module csv_record_splitter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_field_end,
   output logic       rsp_record_end,
   output logic [7:0] rsp_column_count,
   output logic       rsp_unterminated,
   output logic       rsp_field_overflow
);
   import csvrs_pkg::*;

   cmd_type          push_data, head;
   wr_type           buf_wr;
   queue_status_type q_status;
   logic             push, pop, back_idle, front_go;

   assign front_go = back_idle && !q_status.not_empty;

   csvrs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_data_byte (req_data_byte),
      .go            (front_go),
      .cmd_push      (push),
      .cmd_data      (push_data),
      .buf_wr        (buf_wr)
   );

   csvrs_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   csvrs_back u_back (
      .clock              (clock),
      .reset              (reset),
      .buf_wr             (buf_wr),
      .cmd_head           (head),
      .q_status           (q_status),
      .cmd_pop            (pop),
      .idle               (back_idle),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_field_end      (rsp_field_end),
      .rsp_record_end     (rsp_record_end),
      .rsp_column_count   (rsp_column_count),
      .rsp_unterminated   (rsp_unterminated),
      .rsp_field_overflow (rsp_field_overflow)
   );

endmodule

FILE: tb/sv/csvrs_checker.sv
// Checker for the CSV record splitter: predicts field results and compares each transfer.
`timescale 1ns / 1ps

module csvrs_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_data_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_byte_valid,
   input  logic       rsp_field_end,
   input  logic       rsp_record_end,
   input  logic [7:0] rsp_column_count,
   input  logic       rsp_unterminated,
   input  logic       rsp_field_overflow,
   output int         pending_results,
   output int         error_count
);
   import csvrs_pkg::*;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       field_end;
      logic       record_end;
      logic [7:0] column_count;
      logic       unterminated;
      logic       field_overflow;
   } field_result_type;

   field_result_type expected_fields[$];

   // Parser state of the prediction
   logic       quoted;
   logic       quote_held;
   logic       record_fresh;
   logic [7:0] field_buf [FIELD_BYTES];
   int         field_len;
   logic       field_lost;
   int         record_cols;

   function automatic void clear_parse();
      quoted       = 1'b0;
      quote_held   = 1'b0;
      record_fresh = 1'b1;
      field_len    = 0;
      field_lost   = 1'b0;
      record_cols  = 0;
   endfunction

   function automatic void keep_byte(input logic [7:0] b);
      if (field_len < FIELD_BYTES) begin
         field_buf[field_len] = b;
         field_len++;
      end else begin
         field_lost = 1'b1;
      end
   endfunction

   // Unescape the buffered field into byte results; the last one carries the field flags.
   function automatic void drain_field(input logic closes_record);
      field_result_type r;
      int               lo;
      int               hi;
      int               i;
      int               n;
      logic [7:0]       cols;
      lo = 0;
      hi = field_len;
      n  = 0;
      if (record_cols < MAX_COLUMNS) record_cols++;
      cols = closes_record ? 8'(record_cols) : 8'd0;
      if (hi >= 1 && field_buf[0] == QUOTE_CH && field_buf[hi-1] == QUOTE_CH) begin
         lo = 1;
         hi = hi - 1;
      end
      i = lo;
      while (i < hi) begin
         r            = '0;
         r.out_byte   = field_buf[i];
         r.byte_valid = 1'b1;
         if (field_buf[i] == QUOTE_CH && i + 1 < hi && field_buf[i+1] == QUOTE_CH) i += 2;
         else i += 1;
         if (i >= hi) begin
            r.field_end      = 1'b1;
            r.record_end     = closes_record;
            r.column_count   = cols;
            r.field_overflow = field_lost;
         end
         expected_fields.push_back(r);
         n++;
      end
      if (n == 0) begin
         r                = '0;
         r.field_end      = 1'b1;
         r.record_end     = closes_record;
         r.column_count   = cols;
         r.field_overflow = field_lost;
         expected_fields.push_back(r);
      end
      field_len  = 0;
      field_lost = 1'b0;
   endfunction

   function automatic void take_item(input logic kind, input logic [7:0] b);
      field_result_type r;
      if (kind == KIND_EOS) begin
         if (quote_held) begin
            quote_held = 1'b0;
            quoted     = ~quoted;
         end
         if (quoted) begin
            // Stream ended inside quotes: drop the partial field, give one marker.
            r              = '0;
            r.field_end    = 1'b1;
            r.record_end   = 1'b1;
            r.column_count = 8'(record_cols);
            r.unterminated = 1'b1;
            expected_fields.push_back(r);
         end else if (!record_fresh) begin
            drain_field(1'b1);
         end
         clear_parse();
         return;
      end
      record_fresh = 1'b0;
      if (quote_held) begin
         quote_held = 1'b0;
         if (b == QUOTE_CH) begin
            keep_byte(b);
            return;
         end
         quoted = ~quoted;
      end
      if (b == QUOTE_CH) begin
         keep_byte(b);
         quote_held = 1'b1;
      end else if (!quoted && b == COMMA_CH) begin
         drain_field(1'b0);
      end else if (!quoted && b == LINE_CH) begin
         drain_field(1'b1);
         clear_parse();
      end else begin
         keep_byte(b);
      end
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      field_result_type want;
      if (reset) begin
         clear_parse();
         expected_fields.delete();
      end else begin
         if (req_valid && req_ready) take_item(req_kind, req_data_byte);
         if (rsp_valid && rsp_ready) begin
            if (expected_fields.size() == 0) begin
               $error("rsp_out_byte: expected no transfer, got %0d", rsp_out_byte);
               error_count++;
            end else begin
               want = expected_fields.pop_front();
               check_field("rsp_out_byte", want.out_byte, rsp_out_byte);
               check_field("rsp_byte_valid", want.byte_valid, rsp_byte_valid);
               check_field("rsp_field_end", want.field_end, rsp_field_end);
               check_field("rsp_record_end", want.record_end, rsp_record_end);
               check_field("rsp_column_count", want.column_count, rsp_column_count);
               check_field("rsp_unterminated", want.unterminated, rsp_unterminated);
               check_field("rsp_field_overflow", want.field_overflow, rsp_field_overflow);
            end
         end
      end
      pending_results = expected_fields.size();
   end

endmodule

FILE: tb/sv/tb.sv
// Testbench top for the CSV record splitter: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;
   import csvrs_pkg::*;

   localparam int RANDOM_ITEMS = 320;
   localparam int LONG_HOLD    = 300;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_kind = KIND_TEXT;
   logic [7:0] req_data_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_field_end;
   logic       rsp_record_end;
   logic [7:0] rsp_column_count;
   logic       rsp_unterminated;
   logic       rsp_field_overflow;

   int pending_results;
   int error_count;
   int items_sent = 0;
   int burst_left = 0;
   bit rsp_hold_request = 1'b0;

   always #5 clock = ~clock;

   csv_record_splitter dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_field_end      (rsp_field_end),
      .rsp_record_end     (rsp_record_end),
      .rsp_column_count   (rsp_column_count),
      .rsp_unterminated   (rsp_unterminated),
      .rsp_field_overflow (rsp_field_overflow)
   );

   csvrs_checker field_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_field_end      (rsp_field_end),
      .rsp_record_end     (rsp_record_end),
      .rsp_column_count   (rsp_column_count),
      .rsp_unterminated   (rsp_unterminated),
      .rsp_field_overflow (rsp_field_overflow),
      .pending_results    (pending_results),
      .error_count        (error_count)
   );

   // Mostly short gaps, a few long ones, and now and then a burst with none.
   function automatic int pick_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         burst_left = $urandom_range(10, 40);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == QUOTE_CH || b == COMMA_CH || b == LINE_CH);
      return b;
   endfunction

   // Offer one item, hold it until the transfer, then maybe go idle.
   task automatic send_item(input logic kind, input logic [7:0] b);
      int gap;
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(KIND_TEXT, s[i]);
   endtask

   // Drop valid and wait until every predicted result has been taken.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_results == 0);
      @(posedge clock);
   endtask

   task automatic send_field(input int max_len);
      int n;
      int mode;
      int r;
      mode = $urandom_range(0, 9);
      n    = $urandom_range(0, max_len);
      if (mode < 2) return;
      if (mode < 6) begin
         repeat (n) send_item(KIND_TEXT, plain_char());
         return;
      end
      send_item(KIND_TEXT, QUOTE_CH);
      repeat (n) begin
         r = $urandom_range(0, 9);
         if (r == 0) begin
            send_item(KIND_TEXT, QUOTE_CH);
            send_item(KIND_TEXT, QUOTE_CH);
         end else if (r == 1) begin
            send_item(KIND_TEXT, COMMA_CH);
         end else if (r == 2) begin
            send_item(KIND_TEXT, LINE_CH);
         end else begin
            send_item(KIND_TEXT, plain_char());
         end
      end
      send_item(KIND_TEXT, QUOTE_CH);
   endtask

   task automatic send_record(input int fields, input int max_len);
      for (int f = 0; f < fields; f++) begin
         send_field(max_len);
         if (f < fields - 1) send_item(KIND_TEXT, COMMA_CH);
      end
      if ($urandom_range(0, 9) == 0) send_item(KIND_EOS, 8'($urandom));
      else send_item(KIND_TEXT, LINE_CH);
   endtask

   // Loose bytes weighted toward the delimiters and quotes.
   task automatic send_noise(input int n);
      int r;
      repeat (n) begin
         r = $urandom_range(0, 9);
         case (r)
            0, 1:    send_item(KIND_TEXT, QUOTE_CH);
            2:       send_item(KIND_TEXT, COMMA_CH);
            3:       send_item(KIND_TEXT, LINE_CH);
            4:       send_item(KIND_EOS, 8'($urandom));
            default: send_item(KIND_TEXT, 8'($urandom));
         endcase
      end
   endtask

   // Result side: random stalls, plus one long hold on request.
   initial begin
      int n;
      forever begin
         if (rsp_hold_request) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_hold_request = 1'b0;
         end else begin
            n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(8, 40);
            if (n > 0) begin
               rsp_ready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(20, 60);
         repeat (n) @(posedge clock);
      end
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int r;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty middle field, blank line, quoted delimiters and pairs,
      // unterminated stream, dangling quote at end, end of stream at record start.
      send_text("a,,b\n");
      send_text("\n");
      send_text("\"x,\"\"\n\"\n");
      send_text("\"ab");
      send_item(KIND_EOS, 8'hFF);
      send_item(KIND_EOS, 8'h00);
      send_item(KIND_TEXT, 8'h00);
      send_item(KIND_TEXT, 8'hFF);
      send_item(KIND_TEXT, LINE_CH);
      send_item(KIND_TEXT, QUOTE_CH);
      send_item(KIND_EOS, 8'h5A);
      drain_results();

      // Stall the result side for a long stretch while input keeps coming.
      rsp_hold_request = 1'b1;
      repeat (6) send_record($urandom_range(1, 4), 10);

      // Overflow, plain and quoted.
      repeat (FIELD_BYTES + 6) send_item(KIND_TEXT, plain_char());
      send_item(KIND_TEXT, COMMA_CH);
      send_item(KIND_TEXT, QUOTE_CH);
      repeat (FIELD_BYTES + 4) send_item(KIND_TEXT, plain_char());
      send_item(KIND_TEXT, QUOTE_CH);
      send_item(KIND_TEXT, LINE_CH);
      drain_results();

      while (items_sent < RANDOM_ITEMS) begin
         r = $urandom_range(0, 19);
         if (r < 14) begin
            send_record($urandom_range(1, 5), 12);
         end else if (r < 18) begin
            send_noise($urandom_range(1, 12));
         end else if (r == 18) begin
            // Broken record: open quote, then end of stream.
            send_item(KIND_TEXT, QUOTE_CH);
            repeat ($urandom_range(0, 5)) send_item(KIND_TEXT, plain_char());
            send_item(KIND_EOS, 8'($urandom));
         end else begin
            drain_results();
         end
      end

      drain_results();
      repeat (200) @(posedge clock);
      if (error_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
